FILE: rtl/dllc_pkg.sv
// shared constants and types of the deadband lead-lag controller
`default_nettype none

package dllc_pkg;

	// fixed field widths
	localparam int SETPOINT_W  = 9;
	localparam int ANGLE_FRAC  = 7;
	localparam int SP_SCALED_W = SETPOINT_W + ANGLE_FRAC;
	localparam int DEADBAND_W  = 15;
	localparam int GAIN_W      = 16;
	localparam int CMD_W       = 32;
	localparam int CFG_IDX_W   = 3;

	// parameter defaults
	localparam int DATA_WIDTH_DEF     = 16;
	localparam int COEF_FRAC_BITS_DEF = 12;

	// reset values
	localparam logic [DEADBAND_W-1:0]    DEADBAND_RST  = 15'd128;
	localparam logic signed [GAIN_W-1:0] GAIN_FB_RST   = 16'sd3502;
	localparam logic signed [GAIN_W-1:0] GAIN_NOW_RST  = 16'sd30720;
	localparam logic signed [GAIN_W-1:0] GAIN_PREV_RST = 16'sd28262;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEADBAND      = 3'd0,
		REG_DUTY_MAX      = 3'd1,
		REG_DUTY_MIN      = 3'd2,
		REG_SHUTDOWN      = 3'd3,
		REG_GAIN_FEEDBACK = 3'd4,
		REG_GAIN_NOW      = 3'd5,
		REG_GAIN_PREV     = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic signed [GAIN_W-1:0] feedback;
		logic signed [GAIN_W-1:0] now;
		logic signed [GAIN_W-1:0] prev;
	} gains_t;

endpackage

`default_nettype wire

FILE: rtl/dllc_ifs.sv
// valid/ready channels carrying sample and result words
`default_nettype none

interface dllc_sample_if #(
	parameter int DATA_WIDTH = dllc_pkg::DATA_WIDTH_DEF
);
	logic                                  valid;
	logic                                  ready;
	logic signed [DATA_WIDTH-1:0]          angle;
	logic signed [dllc_pkg::SETPOINT_W-1:0] setpoint;

	modport source (output valid, output angle, output setpoint, input ready);
	modport sink   (input valid, input angle, input setpoint, output ready);
endinterface

interface dllc_result_if #(
	parameter int DATA_WIDTH = dllc_pkg::DATA_WIDTH_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] duty;

	modport source (output valid, output duty, input ready);
	modport sink   (input valid, input duty, output ready);
endinterface

`default_nettype wire

FILE: rtl/dllc_law.sv
// lead-lag difference equation: three products, rounding and 32-bit saturation
`default_nettype none

module dllc_law #(
	parameter int DATA_WIDTH     = dllc_pkg::DATA_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = dllc_pkg::COEF_FRAC_BITS_DEF
) (
	input  wire dllc_pkg::gains_t gains,
	input  wire logic signed [((DATA_WIDTH > dllc_pkg::SP_SCALED_W) ? DATA_WIDTH
		: dllc_pkg::SP_SCALED_W) + 1:0] err,
	input  wire logic signed [((DATA_WIDTH > dllc_pkg::SP_SCALED_W) ? DATA_WIDTH
		: dllc_pkg::SP_SCALED_W) + 1:0] last_error,
	input  wire logic signed [dllc_pkg::CMD_W-1:0] last_command,
	output logic signed [dllc_pkg::CMD_W-1:0] command
);

	localparam int ERR_W  = ((DATA_WIDTH > dllc_pkg::SP_SCALED_W) ? DATA_WIDTH
		: dllc_pkg::SP_SCALED_W) + 2;
	localparam int PFB_W  = dllc_pkg::GAIN_W + dllc_pkg::CMD_W;
	localparam int PERR_W = dllc_pkg::GAIN_W + ERR_W;
	localparam int SUM_W  = ((PFB_W > PERR_W) ? PFB_W : PERR_W) + 2;
	localparam int HI_W   = SUM_W - dllc_pkg::CMD_W + 1;
	localparam logic signed [SUM_W-1:0] HALF = SUM_W'(64'd1 << (COEF_FRAC_BITS - 1));

	logic signed [PFB_W-1:0]  p_fb;
	logic signed [PERR_W-1:0] p_now;
	logic signed [PERR_W-1:0] p_prev;
	logic signed [SUM_W-1:0]  sum;
	logic signed [SUM_W-1:0]  rnd;
	logic [HI_W-1:0]          hi;

	assign p_fb   = gains.feedback * last_command;
	assign p_now  = gains.now * err;
	assign p_prev = gains.prev * last_error;

	assign sum = SUM_W'(p_fb) + SUM_W'(p_now) - SUM_W'(p_prev) + HALF;
	// floor shift gives round half up
	assign rnd = sum >>> COEF_FRAC_BITS;
	assign hi  = rnd[SUM_W-1:dllc_pkg::CMD_W-1];

	always_comb begin
		if ((&hi) || !(|hi)) begin
			command = rnd[dllc_pkg::CMD_W-1:0];
		end else if (rnd[SUM_W-1]) begin
			command = {1'b1, {(dllc_pkg::CMD_W-1){1'b0}}};
		end else begin
			command = {1'b0, {(dllc_pkg::CMD_W-1){1'b1}}};
		end
	end

endmodule

`default_nettype wire

FILE: rtl/deadband_lead_lag_controller.sv
// top level of the deadband lead-lag controller
//
// One sample word is taken per clock while the result side is not stalled; its duty word
// passes through the first register, which holds the deadbanded error, and the second,
// which holds the clamped duty. Throughput is one word per cycle without stalls, set by the
// loop from the stored command through the feedback multiply, rounding and saturation back
// into the stored command. A stalled result lets one more sample into the empty first
// register and then stops the input.
// Registers are to be written through cfg_we/cfg_index/cfg_data only while no word is in
// flight; the block itself does not enforce this. Unknown indexes are ignored.
`default_nettype none

module deadband_lead_lag_controller #(
	parameter int DATA_WIDTH     = dllc_pkg::DATA_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = dllc_pkg::COEF_FRAC_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [dllc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [((DATA_WIDTH > dllc_pkg::GAIN_W) ? DATA_WIDTH
		: dllc_pkg::GAIN_W)-1:0] cfg_data,
	dllc_sample_if.sink   sample,
	dllc_result_if.source result
);

	localparam int ERR_W = ((DATA_WIDTH > dllc_pkg::SP_SCALED_W) ? DATA_WIDTH
		: dllc_pkg::SP_SCALED_W) + 2;
	localparam int CMD_W = dllc_pkg::CMD_W;
	localparam logic signed [DATA_WIDTH-1:0] DUTY_MAX_RST = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [DATA_WIDTH-1:0] DUTY_MIN_RST = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	// configuration registers
	logic [dllc_pkg::DEADBAND_W-1:0] deadband_q;
	logic signed [DATA_WIDTH-1:0]    duty_max_q;
	logic signed [DATA_WIDTH-1:0]    duty_min_q;
	logic                            shutdown_q;
	dllc_pkg::gains_t                gains_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q       <= dllc_pkg::DEADBAND_RST;
			duty_max_q       <= DUTY_MAX_RST;
			duty_min_q       <= DUTY_MIN_RST;
			shutdown_q       <= 1'b0;
			gains_q.feedback <= dllc_pkg::GAIN_FB_RST;
			gains_q.now      <= dllc_pkg::GAIN_NOW_RST;
			gains_q.prev     <= dllc_pkg::GAIN_PREV_RST;
		end else if (cfg_we) begin
			case (dllc_pkg::reg_idx_t'(cfg_index))
				dllc_pkg::REG_DEADBAND:      deadband_q <= cfg_data[dllc_pkg::DEADBAND_W-1:0];
				dllc_pkg::REG_DUTY_MAX:      duty_max_q <= cfg_data[DATA_WIDTH-1:0];
				dllc_pkg::REG_DUTY_MIN:      duty_min_q <= cfg_data[DATA_WIDTH-1:0];
				dllc_pkg::REG_SHUTDOWN:      shutdown_q <= cfg_data[0];
				dllc_pkg::REG_GAIN_FEEDBACK: gains_q.feedback <= cfg_data[dllc_pkg::GAIN_W-1:0];
				dllc_pkg::REG_GAIN_NOW:      gains_q.now <= cfg_data[dllc_pkg::GAIN_W-1:0];
				dllc_pkg::REG_GAIN_PREV:     gains_q.prev <= cfg_data[dllc_pkg::GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// error and deadband on the incoming word
	logic signed [dllc_pkg::SP_SCALED_W-1:0] sp_scaled;
	logic signed [ERR_W-1:0]                 err_raw;
	logic [ERR_W-1:0]                        err_mag;
	logic signed [ERR_W-1:0]                 err_db;

	assign sp_scaled = {sample.setpoint, {dllc_pkg::ANGLE_FRAC{1'b0}}};
	assign err_raw   = ERR_W'(sp_scaled) - ERR_W'(sample.angle);
	assign err_mag   = err_raw[ERR_W-1] ? ERR_W'(-err_raw) : ERR_W'(err_raw);
	assign err_db    = (err_mag < ERR_W'(deadband_q)) ? '0 : err_raw;

	// pipeline control
	logic                    valid_s1;
	logic signed [ERR_W-1:0] err_s1;
	logic                    valid_s2;
	logic signed [DATA_WIDTH-1:0] duty_s2;
	logic                    adv_out;
	logic                    take_s1;
	logic                    accept;

	assign adv_out      = !valid_s2 || result.ready;
	assign take_s1      = valid_s1 && adv_out;
	assign sample.ready = !valid_s1 || adv_out;
	assign accept       = sample.valid && sample.ready;

	// recursion state
	logic signed [ERR_W-1:0] last_error_q;
	logic signed [CMD_W-1:0] last_command_q;
	logic signed [CMD_W-1:0] command;

	dllc_law #(
		.DATA_WIDTH     (DATA_WIDTH),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_law (
		.gains        (gains_q),
		.err          (err_s1),
		.last_error   (last_error_q),
		.last_command (last_command_q),
		.command      (command)
	);

	// clamp: upper limit first, then lower, so inverted limits give duty_min
	logic signed [CMD_W-1:0]      lim_hi;
	logic signed [CMD_W-1:0]      lim_lo;
	logic signed [CMD_W-1:0]      clamped;
	logic signed [DATA_WIDTH-1:0] duty_next;

	assign lim_hi = CMD_W'(duty_max_q);
	assign lim_lo = CMD_W'(duty_min_q);

	always_comb begin
		clamped = command;
		if (clamped > lim_hi) begin
			clamped = lim_hi;
		end
		if (clamped < lim_lo) begin
			clamped = lim_lo;
		end
		duty_next = shutdown_q ? '0 : clamped[DATA_WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			last_error_q   <= '0;
			last_command_q <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (take_s1) begin
				valid_s1 <= 1'b0;
			end
			if (take_s1) begin
				valid_s2       <= 1'b1;
				last_error_q   <= err_s1;
				last_command_q <= command;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			err_s1 <= err_db;
		end
		if (take_s1) begin
			duty_s2 <= duty_next;
		end
	end

	assign result.valid = valid_s2;
	assign result.duty  = duty_s2;

endmodule

`default_nettype wire

FILE: sim/tb_deadband_lead_lag_controller.sv
// testbench for the deadband lead-lag controller: directed and random samples against a predictor
`timescale 1ns / 100ps

module tb_deadband_lead_lag_controller;
	import dllc_pkg::*;

	localparam int DW          = DATA_WIDTH_DEF;
	localparam int CFG_W       = (DW > GAIN_W) ? DW : GAIN_W;
	localparam int COEF_FRAC   = COEF_FRAC_BITS_DEF;
	localparam int ERR_W       = DW + 2;
	localparam int PERIOD      = 4;
	localparam int CYCLE_LIMIT = 200000;
	localparam int REPORT_MAX  = 10;
	localparam int HOLD_CYCLES = 200;

	localparam logic [CFG_IDX_W-1:0]    REG_UNUSED = 3'd7;
	localparam logic signed [DW-1:0]    ANGLE_MIN  = {1'b1, {(DW-1){1'b0}}};
	localparam logic signed [DW-1:0]    ANGLE_MAX  = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [SETPOINT_W-1:0] SP_MIN = {1'b1, {(SETPOINT_W-1){1'b0}}};
	localparam logic signed [SETPOINT_W-1:0] SP_MAX = {1'b0, {(SETPOINT_W-1){1'b1}}};

	class duty_scoreboard;
		logic [DEADBAND_W-1:0]    deadband;
		logic signed [DW-1:0]     duty_max;
		logic signed [DW-1:0]     duty_min;
		logic                     shutdown;
		logic signed [GAIN_W-1:0] gain_fb;
		logic signed [GAIN_W-1:0] gain_now;
		logic signed [GAIN_W-1:0] gain_prev;
		logic signed [ERR_W-1:0]  last_error;
		logic signed [CMD_W-1:0]  last_command;
		logic signed [DW-1:0]     expected_duty[$];
		int mismatches;
		int samples;
		int checked;

		function new();
			deadband     = DEADBAND_RST;
			duty_max     = ANGLE_MAX;
			duty_min     = ANGLE_MIN;
			shutdown     = 1'b0;
			gain_fb      = GAIN_FB_RST;
			gain_now     = GAIN_NOW_RST;
			gain_prev    = GAIN_PREV_RST;
			last_error   = '0;
			last_command = '0;
			mismatches   = 0;
			samples      = 0;
			checked      = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_DEADBAND:      deadband  = data[DEADBAND_W-1:0];
				REG_DUTY_MAX:      duty_max  = data[DW-1:0];
				REG_DUTY_MIN:      duty_min  = data[DW-1:0];
				REG_SHUTDOWN:      shutdown  = data[0];
				REG_GAIN_FEEDBACK: gain_fb   = data[GAIN_W-1:0];
				REG_GAIN_NOW:      gain_now  = data[GAIN_W-1:0];
				REG_GAIN_PREV:     gain_prev = data[GAIN_W-1:0];
				default: ;
			endcase
		endfunction

		// one accepted sample: step the compensator and queue the duty it gives
		function void note_sample(logic signed [DW-1:0] angle,
				logic signed [SETPOINT_W-1:0] setpoint);
			longint err;
			longint mag;
			longint acc;
			longint cmd;
			longint cmd_max;
			longint cmd_min;
			logic signed [DW-1:0] duty;
			cmd_max = (longint'(1) <<< (CMD_W - 1)) - 1;
			cmd_min = -(longint'(1) <<< (CMD_W - 1));
			err = (longint'(setpoint) <<< ANGLE_FRAC) - longint'(angle);
			mag = (err < 0) ? -err : err;
			if (mag < longint'(deadband))
				err = 0;
			acc = longint'(gain_fb) * longint'(last_command) + longint'(gain_now) * err
				- longint'(gain_prev) * longint'(last_error);
			// round half up, then back to the angle scale
			cmd = (acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
			if (cmd > cmd_max)
				cmd = cmd_max;
			if (cmd < cmd_min)
				cmd = cmd_min;
			last_error   = err[ERR_W-1:0];
			last_command = cmd[CMD_W-1:0];
			// upper clamp first, so inverted limits give duty_min
			if (cmd > longint'(duty_max))
				cmd = longint'(duty_max);
			if (cmd < longint'(duty_min))
				cmd = longint'(duty_min);
			duty = shutdown ? '0 : cmd[DW-1:0];
			expected_duty.push_back(duty);
			samples++;
		endfunction

		function void check_duty(logic signed [DW-1:0] duty);
			logic signed [DW-1:0] want;
			checked++;
			if (expected_duty.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("duty word %0d: got %0d with nothing pending", checked, duty);
				return;
			end
			want = expected_duty.pop_front();
			if (duty !== want) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("duty word %0d: expected %0d, got %0d", checked, want, duty);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	dllc_sample_if #(.DATA_WIDTH(DW)) sample_ch ();
	dllc_result_if #(.DATA_WIDTH(DW)) result_ch ();

	deadband_lead_lag_controller #(
		.DATA_WIDTH(DW),
		.COEF_FRAC_BITS(COEF_FRAC)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.sample(sample_ch),
		.result(result_ch)
	);

	duty_scoreboard sb = new();

	int send_idle_pct;
	int recv_stall_pct;
	int hold_count;
	int cycles;
	int reg_writes;
	int phases;

	initial clk = 1'b0;
	always #(PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("timed out after %0d cycles, %0d duty words pending", cycles,
			sb.expected_duty.size());
		$display("end of test: mismatches");
		$finish;
	end

	// result side: random stalls, plus a long hold-off counted here
	initial begin : result_sink
		int hold_left;
		int holds_seen;
		hold_left = 0;
		holds_seen = 0;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready)
				sb.check_duty(result_ch.duty);
			@(negedge clk);
			if (hold_count != holds_seen) begin
				hold_left = HOLD_CYCLES;
				holds_seen = hold_count;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// called and returns at a falling edge
	task automatic send_sample(logic signed [DW-1:0] angle,
			logic signed [SETPOINT_W-1:0] setpoint);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(negedge clk);
		end
		sample_ch.valid    <= 1'b1;
		sample_ch.angle    <= angle;
		sample_ch.setpoint <= setpoint;
		do @(posedge clk); while (!sample_ch.ready);
		sb.note_sample(angle, setpoint);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.set_reg(idx, data);
		reg_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (sb.expected_duty.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// mostly errors near the setpoint or on the deadband edge, some full range
	task automatic run_phase(int idle, int stall, int count);
		logic signed [SETPOINT_W-1:0] sp;
		logic signed [DW-1:0] ang;
		int target;
		int delta;
		send_idle_pct  = idle;
		recv_stall_pct = stall;
		for (int i = 0; i < count; i++) begin
			sp = SETPOINT_W'($urandom);
			case ($urandom_range(3))
				0: ang = DW'($urandom);
				1: begin
					delta = int'($urandom_range(1024)) - 512;
					target = (int'(sp) * 128) + delta;
					ang = target[DW-1:0];
				end
				default: begin
					delta = int'(sb.deadband) - int'($urandom_range(1));
					if ($urandom_range(1))
						delta = -delta;
					target = (int'(sp) * 128) - delta;
					ang = target[DW-1:0];
				end
			endcase
			send_sample(ang, sp);
		end
		sample_ch.valid <= 1'b0;
		wait_drained();
		phases++;
	endtask

	initial begin : stimulus
		int idle_set [3];
		int stall_set [3];
		idle_set  = '{54, 0, 23};
		stall_set = '{0, 54, 23};
		arst_n             = 1'b0;
		sample_ch.valid    = 1'b0;
		sample_ch.angle    = '0;
		sample_ch.setpoint = '0;
		cfg_we             = 1'b0;
		cfg_index          = '0;
		cfg_data           = '0;
		send_idle_pct      = 0;
		recv_stall_pct     = 0;
		hold_count         = 0;
		reg_writes         = 0;
		phases             = 0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// field extremes and the deadband edge at reset settings
		send_sample(0, 0);
		send_sample(ANGLE_MAX, SP_MIN);
		send_sample(ANGLE_MIN, SP_MAX);
		send_sample(ANGLE_MIN, SP_MIN);
		send_sample(ANGLE_MAX, SP_MAX);
		send_sample(0, 1);
		send_sample(1, 1);
		send_sample(256, 1);
		send_sample(255, 1);
		send_sample(0, 0);
		repeat (4) send_sample(ANGLE_MIN, SP_MAX);
		repeat (4) send_sample(ANGLE_MAX, SP_MIN);
		repeat (3) send_sample(0, 0);
		sample_ch.valid <= 1'b0;
		wait_drained();

		// result side held off while samples keep coming
		hold_count++;
		run_phase(0, 0, 300);

		// no deadband, narrow clamps
		write_reg(REG_DEADBAND, 0);
		write_reg(REG_DUTY_MAX, 1000);
		write_reg(REG_DUTY_MIN, -1000);
		run_phase(54, 0, 300);

		// shutdown with full deadband and saturating gains
		write_reg(REG_SHUTDOWN, 1);
		write_reg(REG_DEADBAND, 32767);
		write_reg(REG_GAIN_FEEDBACK, 32767);
		write_reg(REG_GAIN_NOW, -32768);
		write_reg(REG_GAIN_PREV, 32767);
		run_phase(0, 54, 250);

		// inverted clamps, gains at the other extreme
		write_reg(REG_SHUTDOWN, 0);
		write_reg(REG_DUTY_MIN, 500);
		write_reg(REG_DUTY_MAX, -500);
		write_reg(REG_GAIN_FEEDBACK, -32768);
		write_reg(REG_GAIN_NOW, 32767);
		write_reg(REG_GAIN_PREV, -32768);
		run_phase(23, 23, 250);

		// unknown index must change nothing
		write_reg(REG_UNUSED, 16'hFFFF);
		write_reg(REG_DUTY_MAX, 32767);
		write_reg(REG_DUTY_MIN, -32768);
		write_reg(REG_GAIN_FEEDBACK, 2048);
		write_reg(REG_GAIN_NOW, 4096);
		write_reg(REG_GAIN_PREV, 2048);
		write_reg(REG_DEADBAND, 64);
		run_phase(0, 0, 250);

		for (int k = 0; k < 3; k++) begin
			write_reg(REG_DEADBAND,
				CFG_W'(($urandom_range(1) << 15) | $urandom_range(1023)));
			write_reg(REG_DUTY_MAX, CFG_W'($urandom));
			write_reg(REG_DUTY_MIN, CFG_W'($urandom));
			write_reg(REG_SHUTDOWN, ($urandom_range(3) == 0));
			write_reg(REG_GAIN_FEEDBACK, CFG_W'($urandom));
			write_reg(REG_GAIN_NOW, CFG_W'($urandom));
			write_reg(REG_GAIN_PREV, CFG_W'($urandom));
			run_phase(idle_set[k], stall_set[k], 200);
		end

		repeat (8) @(posedge clk);
		$display("%0d samples in %0d random phases, %0d duty words compared, %0d register writes",
			sb.samples, phases, sb.checked, reg_writes);
		$display("ran deadband off and full, narrow and inverted clamps, shutdown, saturating gains");
		if (sb.expected_duty.size() != 0)
			$display("%0d duty words never arrived", sb.expected_duty.size());
		if (sb.mismatches == 0 && sb.expected_duty.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
